[hdl/cor_pkg.sv]
package cor_pkg;

    // fixed widths of the pixel and canvas fields
    localparam int PIX_W       = 15;
    localparam int HEIGHT_W    = 13;
    localparam int COORD_W_DEF = 12;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // octant that closes a step
    localparam logic [2:0] OCT_LAST = 3'd7;

    // square root unit handshake
    typedef struct packed {
        logic start;
    } t_sqrt_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_sts;

endpackage

[hdl/cor_isqrt.sv]
module cor_isqrt #(
    parameter int N = cor_pkg::COORD_W_DEF + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cor_pkg::t_sqrt_ctl i_ctl,
    input  logic [2*N-1:0]     i_operand,
    output cor_pkg::t_sqrt_sts o_sts,
    output logic [N-1:0]       o_root
);

    localparam int IW = $clog2(N + 1);

    logic [2*N-1:0] r_v,    n_v;
    logic [N-1:0]   r_rem,  n_rem;
    logic [N-1:0]   r_root, n_root;
    logic [IW-1:0]  r_cnt,  n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;

    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    logic [N+1:0] diff;
    logic         ge;

    // one root bit per cycle: bring down two operand bits, try 4*root+1
    always_comb begin
        rem_sh = {r_rem, r_v[2*N-1 -: 2]};
        trial  = {r_root, 2'b01};
        ge     = (rem_sh >= trial);
        diff   = rem_sh - trial;

        n_v    = r_v;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start) begin
            n_v    = i_operand;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = IW'(N);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_v    = r_v << 2;
            n_rem  = ge ? diff[N-1:0] : rem_sh[N-1:0];
            n_root = {r_root[N-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == IW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_v    <= n_v;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_root;

endmodule

[hdl/circle_octant_rasterizer.sv]
// circle_octant_rasterizer: eight-way symmetric circle from the explicit equation
//
// input channel (i_in_valid / o_in_ready): a transfer with i_func = 0 starts a
// circle from a centre and a point on it; i_func = 1 asks for the next step.
// a step of an active circle yields eight pixel transfers on the output channel
// (o_out_valid / i_out_ready) in octant order 0..7; a step while idle yields none.
// config channel (i_cfg_valid / o_cfg_ready, always ready) writes the canvas height,
// used to flip upward y into screen rows; write it only while idle.
//
// start: two shift-add squares, one bit per cycle, then the step limit root,
//   all before the next input transfer.
// step: a bit-serial square root, then one pixel per cycle into the output
//   register while the receiver does not stall.
// x*x is tracked by an add per step, so a step needs no multiplier.
// a stalled receiver holds the output register and the step waits there;
// input is taken again once the eighth pixel is in the output register.
// reset: idle, no circle, height 480, output register empty.
module circle_octant_rasterizer #(
    parameter int COORD_BITS = cor_pkg::COORD_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cor_pkg::HEIGHT_W-1:0] i_cfg_data,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_func,
    input  logic [COORD_BITS-1:0]        i_centre_x,
    input  logic [COORD_BITS-1:0]        i_centre_y,
    input  logic [COORD_BITS-1:0]        i_edge_x,
    input  logic [COORD_BITS-1:0]        i_edge_y,
    // pixel results
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [cor_pkg::PIX_W-1:0] o_pixel_col,
    output logic signed [cor_pkg::PIX_W-1:0] o_pixel_row,
    output logic [2:0]                   o_octant_index,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);

    localparam int W  = COORD_BITS;
    localparam int N  = W + 1;            // root bits
    localparam int RW = 2 * W + 1;        // squared radius bits
    localparam int QW = 2 * W + 2;        // root operand and x*x bits
    localparam int CW = $clog2(W);
    localparam int PW = cor_pkg::PIX_W;
    localparam int HW = cor_pkg::HEIGHT_W;
    localparam int AW = (W + 2 > PW) ? W + 2 : PW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;  // shift-add squares of dx and dy
    localparam logic [2:0] S_LIM  = 3'd2;  // root of rsq/2 for the step limit
    localparam logic [2:0] S_ROOT = 3'd3;  // root of rsq - x*x
    localparam logic [2:0] S_EMIT = 3'd4;  // eight pixels out

    logic [2:0]    r_state,  n_state;
    logic [W-1:0]  r_cx,     n_cx;
    logic [W-1:0]  r_cy,     n_cy;
    logic [RW-1:0] r_rsq,    n_rsq;
    logic [W:0]    r_limit,  n_limit;
    logic [W:0]    r_step_x, n_step_x;
    logic [QW-1:0] r_xsq,    n_xsq;
    logic          r_active, n_active;
    logic [2*W-1:0] r_mca,   n_mca;
    logic [W-1:0]  r_mcb,    n_mcb;
    logic [W-1:0]  r_dy_abs, n_dy_abs;
    logic          r_pass,   n_pass;
    logic [CW-1:0] r_cnt,    n_cnt;
    logic          r_kick,   n_kick;
    logic [N-1:0]  r_y,      n_y;
    logic [2:0]    r_oct,    n_oct;
    logic [HW-1:0] r_height;

    logic          r_out_valid, n_out_valid;
    logic [PW-1:0] r_col,  n_col;
    logic [PW-1:0] r_row,  n_row;
    logic [2:0]    r_octo, n_octo;
    logic          r_last, n_last;
    logic          r_done, n_done;

    cor_pkg::t_sqrt_ctl sq_ctl;
    cor_pkg::t_sqrt_sts sq_sts;
    logic [QW-1:0]      sq_op;
    logic [N-1:0]       sq_root;

    logic          in_xfer;
    logic          load;
    logic          step_done;
    logic [W:0]    dx, dy;
    logic [W-1:0]  dx_abs, dy_abs;
    logic [QW-1:0] rsq_e;
    logic          csub, rsub;
    logic [AW-1:0] cx_e, cy_e, a_e, b_e, col_e, up_e, row_e;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign load        = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign step_done   = (r_step_x >= r_limit);

    // start: absolute offsets from the centre
    assign dx     = {1'b0, i_edge_x} - {1'b0, i_centre_x};
    assign dy     = {1'b0, i_edge_y} - {1'b0, i_centre_y};
    assign dx_abs = dx[W] ? W'(-dx) : dx[W-1:0];
    assign dy_abs = dy[W] ? W'(-dy) : dy[W-1:0];

    // root operand: rsq/2 for the limit, clamped rsq - x*x for a step
    assign rsq_e = {1'b0, r_rsq};
    always_comb begin
        if (r_state == S_LIM) begin
            sq_op = {2'b00, r_rsq[RW-1:1]};
        end else if (rsq_e > r_xsq) begin
            sq_op = rsq_e - r_xsq;
        end else begin
            sq_op = '0;
        end
    end
    assign sq_ctl.start = r_kick;

    cor_isqrt #(
        .N(N)
    ) u_isqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (sq_ctl),
        .i_operand(sq_op),
        .o_sts    (sq_sts),
        .o_root   (sq_root)
    );

    // octant decode: which offset goes on which axis and with which sign
    always_comb begin
        unique case (r_oct)
            3'd0:    begin csub = 1'b0; rsub = 1'b0; end
            3'd1:    begin csub = 1'b0; rsub = 1'b1; end
            3'd2:    begin csub = 1'b1; rsub = 1'b0; end
            3'd3:    begin csub = 1'b1; rsub = 1'b1; end
            3'd4:    begin csub = 1'b0; rsub = 1'b0; end
            3'd5:    begin csub = 1'b1; rsub = 1'b0; end
            3'd6:    begin csub = 1'b0; rsub = 1'b1; end
            default: begin csub = 1'b1; rsub = 1'b1; end
        endcase
    end

    // pixel arithmetic wraps, only the low pixel bits are kept
    assign cx_e  = AW'(r_cx);
    assign cy_e  = AW'(r_cy);
    assign a_e   = AW'(r_oct[2] ? r_y : r_step_x);
    assign b_e   = AW'(r_oct[2] ? r_step_x : r_y);
    assign col_e = csub ? cx_e - a_e : cx_e + a_e;
    assign up_e  = rsub ? cy_e - b_e : cy_e + b_e;
    assign row_e = AW'(r_height) - up_e;

    always_comb begin
        n_state  = r_state;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rsq    = r_rsq;
        n_limit  = r_limit;
        n_step_x = r_step_x;
        n_xsq    = r_xsq;
        n_active = r_active;
        n_mca    = r_mca;
        n_mcb    = r_mcb;
        n_dy_abs = r_dy_abs;
        n_pass   = r_pass;
        n_cnt    = r_cnt;
        n_kick   = 1'b0;
        n_y      = r_y;
        n_oct    = r_oct;

        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        n_col  = r_col;
        n_row  = r_row;
        n_octo = r_octo;
        n_last = r_last;
        n_done = r_done;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (!i_func) begin
                        n_cx     = i_centre_x;
                        n_cy     = i_centre_y;
                        n_rsq    = '0;
                        n_mca    = {{W{1'b0}}, dx_abs};
                        n_mcb    = dx_abs;
                        n_dy_abs = dy_abs;
                        n_pass   = 1'b0;
                        n_cnt    = '0;
                        n_state  = S_SQ;
                    end else if (r_active) begin
                        n_kick  = 1'b1;
                        n_state = S_ROOT;
                    end
                end
            end
            S_SQ: begin
                // one multiplier bit per cycle
                if (r_mcb[0]) begin
                    n_rsq = r_rsq + {1'b0, r_mca};
                end
                n_mca = r_mca << 1;
                n_mcb = r_mcb >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_cnt = '0;
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_mca  = {{W{1'b0}}, r_dy_abs};
                        n_mcb  = r_dy_abs;
                    end else begin
                        n_kick  = 1'b1;
                        n_state = S_LIM;
                    end
                end
            end
            S_LIM: begin
                if (sq_sts.done) begin
                    n_limit  = sq_root[W:0] + 1'b1;
                    n_step_x = '0;
                    n_xsq    = '0;
                    n_active = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_ROOT: begin
                if (sq_sts.done) begin
                    n_y     = sq_root;
                    n_oct   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_col  = col_e[PW-1:0];
                    n_row  = row_e[PW-1:0];
                    n_octo = r_oct;
                    n_last = (r_oct == cor_pkg::OCT_LAST);
                    n_done = step_done;
                    n_oct  = r_oct + 1'b1;
                    if (r_oct == cor_pkg::OCT_LAST) begin
                        n_state = S_IDLE;
                        if (step_done) begin
                            n_active = 1'b0;
                        end else begin
                            // (x+1)^2 = x^2 + 2x + 1
                            n_step_x = r_step_x + 1'b1;
                            n_xsq    = r_xsq + {{W{1'b0}}, r_step_x, 1'b1};
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cx        <= '0;
            r_cy        <= '0;
            r_rsq       <= '0;
            r_limit     <= '0;
            r_step_x    <= '0;
            r_xsq       <= '0;
            r_active    <= 1'b0;
            r_pass      <= 1'b0;
            r_cnt       <= '0;
            r_kick      <= 1'b0;
            r_oct       <= '0;
            r_height    <= cor_pkg::HEIGHT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_rsq       <= n_rsq;
            r_limit     <= n_limit;
            r_step_x    <= n_step_x;
            r_xsq       <= n_xsq;
            r_active    <= n_active;
            r_pass      <= n_pass;
            r_cnt       <= n_cnt;
            r_kick      <= n_kick;
            r_oct       <= n_oct;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_height <= i_cfg_data;
            end
        end
        r_mca    <= n_mca;
        r_mcb    <= n_mcb;
        r_dy_abs <= n_dy_abs;
        r_y      <= n_y;
        r_col    <= n_col;
        r_row    <= n_row;
        r_octo   <= n_octo;
        r_last   <= n_last;
        r_done   <= n_done;
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_col    = r_col;
    assign o_pixel_row    = r_row;
    assign o_octant_index = r_octo;
    assign o_last_of_step = r_last;
    assign o_circle_done  = r_done;

    // the root unit only runs for a limit or a step
    a_sqrt_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_sts.busy || sq_sts.done) |-> (r_state == S_LIM || r_state == S_ROOT))
        else $error("root unit active outside a root state");

    // x never passes the limit of an active circle
    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_step_x <= r_limit))
        else $error("step x beyond limit");

    // the running x*x stays equal to the square of x
    a_xsq_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_xsq == QW'(r_step_x) * QW'(r_step_x)))
        else $error("x squared out of step with x");

    // the eighth pixel closes the step and frees the input
    a_step_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_oct == cor_pkg::OCT_LAST) |=> (r_state == S_IDLE && o_out_valid))
        else $error("step did not close after octant seven");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int CW            = cor_pkg::COORD_W_DEF;
    localparam int PW            = cor_pkg::PIX_W;
    localparam int HW            = cor_pkg::HEIGHT_W;
    localparam int COORD_MAX     = (1 << CW) - 1;
    localparam logic [CW-1:0] COORD_TOP = '1;
    // settle wait, long enough for a start or a step with no pixels to finish
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 50;

    // input item codes
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // one expected pixel transfer
    typedef struct {
        logic signed [PW-1:0] col;
        logic signed [PW-1:0] row;
        logic [2:0]           oct;
        logic                 last;
        logic                 done;
    } t_pixel;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // config channel
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [HW-1:0] i_cfg_data  = '0;

    // input channel
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    logic          i_func     = 1'b0;
    logic [CW-1:0] i_centre_x = '0;
    logic [CW-1:0] i_centre_y = '0;
    logic [CW-1:0] i_edge_x   = '0;
    logic [CW-1:0] i_edge_y   = '0;

    // pixel channel
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [PW-1:0] o_pixel_col;
    logic signed [PW-1:0] o_pixel_row;
    logic [2:0]           o_octant_index;
    logic                 o_last_of_step;
    logic                 o_circle_done;

    // shadow of the block: canvas height and the circle in progress
    logic [HW-1:0] ras_height = cor_pkg::HEIGHT_RESET;
    logic [CW-1:0] ras_col    = '0;
    logic [CW-1:0] ras_up     = '0;
    logic [24:0]   ras_rsq    = '0;
    logic [12:0]   ras_limit  = '0;
    logic [12:0]   ras_x      = '0;
    logic          ras_active = 1'b0;

    t_pixel pending_pixels[$];

    int err_count     = 0;
    int cycle_count   = 0;
    int items_sent    = 0;  // starts and steps of an active circle
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_left  = 0;  // receiver hold-off, counted down by the receiver

    circle_octant_rasterizer #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_centre_x    (i_centre_x),
        .i_centre_y    (i_centre_y),
        .i_edge_x      (i_edge_x),
        .i_edge_y      (i_edge_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_col   (o_pixel_col),
        .o_pixel_row   (o_pixel_row),
        .o_octant_index(o_octant_index),
        .o_last_of_step(o_last_of_step),
        .o_circle_done (o_circle_done)
    );

    initial forever #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_REPORTS)
            $display("tb: mismatch on %s: got %0d, want %0d (cycle %0d)",
                     what, got, want, cycle_count);
        err_count++;
    endtask

    // floor square root, one result bit at a time from the top
    function automatic int floor_sqrt(input longint v);
        int r;
        int t;
        r = 0;
        for (int b = 13; b >= 0; b--) begin
            t = r | (1 << b);
            if (longint'(t) * longint'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    // update the shadow state for one accepted item and queue its pixels
    task automatic predict_octant_pixels(input t_op op, input logic [CW-1:0] cx,
                                         input logic [CW-1:0] cy, input logic [CW-1:0] ex,
                                         input logic [CW-1:0] ey);
        int     dx;
        int     dy;
        int     x;
        int     y;
        int     c;
        int     u;
        int     h;
        longint xs;
        longint rem;
        logic   done;
        int     cols [8];
        int     ups [8];
        t_pixel pix;
        if (op == OP_START) begin
            // new circle replaces whatever was in progress
            dx         = int'(ex) - int'(cx);
            dy         = int'(ey) - int'(cy);
            ras_col    = cx;
            ras_up     = cy;
            ras_rsq    = 25'(dx * dx + dy * dy);
            ras_limit  = 13'(floor_sqrt(longint'(ras_rsq >> 1)) + 1);
            ras_x      = '0;
            ras_active = 1'b1;
            items_sent++;
        end else if (ras_active) begin
            items_sent++;
            xs   = longint'(ras_x) * longint'(ras_x);
            // past the radius the root argument is clamped at zero
            rem  = (longint'(ras_rsq) > xs) ? longint'(ras_rsq) - xs : 0;
            x    = int'(ras_x);
            y    = floor_sqrt(rem);
            c    = int'(ras_col);
            u    = int'(ras_up);
            h    = int'(ras_height);
            done = (ras_x >= ras_limit);
            // octant order: four points mirrored on x, then four on y
            cols = '{c + x, c + x, c - x, c - x, c + y, c - y, c + y, c - y};
            ups  = '{u + y, u - y, u + y, u - y, u + x, u + x, u - x, u - x};
            for (int k = 0; k < 8; k++) begin
                pix.col  = PW'(cols[k]);
                pix.row  = PW'(h - ups[k]);
                pix.oct  = k[2:0];
                pix.last = (k[2:0] == cor_pkg::OCT_LAST);
                pix.done = done;
                pending_pixels = {pending_pixels, pix};
            end
            if (done)
                ras_active = 1'b0;
            else
                ras_x = ras_x + 13'd1;
        end
        // a step while idle changes nothing
    endtask

    // pixel checker: every transfer against the oldest expected pixel
    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with none expected", int'(o_octant_index), -1);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_col !== want.col)
                    report_mismatch("pixel_col", int'(o_pixel_col), int'(want.col));
                if (o_pixel_row !== want.row)
                    report_mismatch("pixel_row", int'(o_pixel_row), int'(want.row));
                if (o_octant_index !== want.oct)
                    report_mismatch("octant_index", int'(o_octant_index), int'(want.oct));
                if (o_last_of_step !== want.last)
                    report_mismatch("last_of_step", int'(o_last_of_step), int'(want.last));
                if (o_circle_done !== want.done)
                    report_mismatch("circle_done", int'(o_circle_done), int'(want.done));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // one input transfer; returns right after the edge that took it, valid still
    // high so that a following item goes back to back
    task automatic push_item(input t_op op, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                             input logic [CW-1:0] ex, input logic [CW-1:0] ey);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= op;
        i_centre_x <= cx;
        i_centre_y <= cy;
        i_edge_x   <= ex;
        i_edge_y   <= ey;
        do @(posedge i_clk); while (!o_in_ready);
        predict_octant_pixels(op, cx, cy, ex, ey);
    endtask

    // step with junk in the coordinate fields, which a step ignores
    task automatic push_step();
        push_item(OP_STEP, CW'($urandom_range(0, COORD_MAX)),
                  CW'($urandom_range(0, COORD_MAX)),
                  CW'($urandom_range(0, COORD_MAX)),
                  CW'($urandom_range(0, COORD_MAX)));
    endtask

    // start a circle, then either run it to its last step or cut it short
    task automatic run_circle(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                              input bit full, input int n_steps);
        int n;
        push_item(OP_START, cx, cy, ex, ey);
        n = full ? int'(ras_limit) + 1 : n_steps;
        repeat (n) push_step();
    endtask

    // coordinate within span of c, kept on the 12 bit grid
    function automatic logic [CW-1:0] near_coord(input int c, input int span);
        int d;
        d = $urandom_range(0, span);
        if ($urandom_range(0, 1))
            d = -d;
        if (c + d < 0 || c + d > COORD_MAX)
            d = -d;
        return CW'(c + d);
    endfunction

    // stop sending, wait for every expected pixel, then let a start finish
    task automatic drain_pixels();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic set_canvas_height(input logic [HW-1:0] h);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        ras_height = h;
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // steps straight out of reset produce nothing
    task automatic test_idle_steps();
        push_step();
        push_step();
    endtask

    // centre on the edge point: zero radius, two steps of y = 0, then idle again
    task automatic test_zero_radius();
        run_circle('0, '0, '0, '0, 1'b1, 0);
        push_step();
    endtask

    // rsq = 2 gives limit 2, so the last step lies past the radius
    task automatic test_clamped_root();
        run_circle(12'd2000, 12'd100, 12'd2001, 12'd101, 1'b1, 0);
    endtask

    // largest radii on a one-row canvas, each circle replaced mid-way
    task automatic test_extreme_circles();
        drain_pixels();
        set_canvas_height(13'd1);
        run_circle(COORD_TOP, COORD_TOP, '0, '0, 1'b0, 3);
        run_circle('0, COORD_TOP, COORD_TOP, '0, 1'b0, 2);
        run_circle('0, '0, COORD_TOP, COORD_TOP, 1'b0, 1);
    endtask

    // canvas height 4096, circle against the right edge of the grid
    task automatic test_tall_canvas();
        drain_pixels();
        set_canvas_height(13'd4096);
        run_circle(COORD_TOP, '0, COORD_TOP - CW'(3), '0, 1'b1, 0);
    endtask

    // mostly complete small circles, some cut short, some large, some stray steps
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [HW-1:0] h, input int n_items);
        int            target;
        int            pick;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        drain_pixels();
        set_canvas_height(h);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target        = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            cx   = CW'($urandom_range(0, COORD_MAX));
            cy   = CW'($urandom_range(0, COORD_MAX));
            if (pick < 75)
                run_circle(cx, cy, near_coord(int'(cx), 16), near_coord(int'(cy), 16),
                           1'b1, 0);
            else if (pick < 85)
                run_circle(cx, cy, near_coord(int'(cx), 16), near_coord(int'(cy), 16),
                           1'b0, $urandom_range(0, 4));
            else if (pick < 93)
                run_circle(cx, cy, CW'($urandom_range(0, COORD_MAX)),
                           CW'($urandom_range(0, COORD_MAX)), 1'b0, $urandom_range(1, 6));
            else
                repeat ($urandom_range(1, 2)) push_step();
        end
    endtask

    // receiver holds off while steps keep coming, so the input side must stall;
    // afterwards the sender waits for every pixel
    task automatic test_backpressure();
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        drain_pixels();
        set_canvas_height(cor_pkg::HEIGHT_RESET);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cx            = CW'($urandom_range(40, COORD_MAX - 40));
        cy            = CW'($urandom_range(40, COORD_MAX - 40));
        rx_hold_left  = 400;
        run_circle(cx, cy, cx + CW'(30), cy, 1'b1, 0);
        drain_pixels();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // directed part on the reset height, then heights 1 and 4096
        send_idle_pct = 26;
        recv_idle_pct = 84;
        test_idle_steps();
        test_zero_radius();
        test_clamped_root();
        test_extreme_circles();
        test_tall_canvas();

        // random part: slow receiver, then slow sender, then a receiver hold-off, then full rate
        test_random_traffic(26, 84, 13'd4095, 120);
        test_random_traffic(84, 26, HW'($urandom_range(1, 4096)), 120);
        test_backpressure();
        test_random_traffic(0, 0, 13'd2048, 120);

        drain_pixels();
        if (pending_pixels.size() != 0)
            report_mismatch("pixels never delivered", 0, pending_pixels.size());
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
